// ===== hdl/ile_pkg.sv =====
package ile_pkg;

    localparam int DEPTH  = 32;
    localparam int POS_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADIDX = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

// ===== hdl/ile_ctrl.sv =====
module ile_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output ile_pkg::t_ctrl o_ctrl
);
    import ile_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_EXEC);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.load = start;
            end
            ST_EXEC: begin
                busy        = 1'b1;
                o_ctrl.exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule

// ===== hdl/ile_datapath.sv =====
module ile_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ile_pkg::t_ctrl              i_ctrl,
    input  logic [ile_pkg::MODE_W-1:0]  i_mode,
    input  logic [ile_pkg::POS_W-1:0]   i_position,
    input  logic signed [ile_pkg::DATA_W-1:0] i_item_value,
    output logic [ile_pkg::STAT_W-1:0]  o_status,
    output logic [ile_pkg::CNT_W-1:0]   o_entry_count
);
    import ile_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;

    logic [DATA_W-1:0] r_entries [DEPTH];
    logic [DATA_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           r_status;
    t_status           n_status;

    logic [CNT_W-1:0] pos_ext;
    logic             is_full;
    logic             is_empty;
    logic             bad_idx;
    logic             do_push;
    logic             do_insert;
    logic             do_erase;

    assign pos_ext  = {1'b0, r_pos};
    assign is_full  = (r_count == CNT_FULL);
    assign is_empty = (r_count == '0);
    assign bad_idx  = (pos_ext >= r_count);

    always_comb begin
        n_status  = STAT_DONE;
        n_count   = r_count;
        do_push   = 1'b0;
        do_insert = 1'b0;
        do_erase  = 1'b0;
        case (r_mode)
            MODE_PUSH: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    do_push = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            MODE_INSERT: begin
                // The index check takes precedence over the full check.
                if (bad_idx) begin
                    n_status = STAT_BADIDX;
                end else if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            MODE_ERASE: begin
                if (bad_idx) begin
                    n_status = STAT_BADIDX;
                end else begin
                    do_erase = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = STAT_DONE;
            end
        endcase
    end

    // Each entry picks from itself, a neighbor or the new value, so the whole
    // row shifts together. Entries at or above the count may take junk.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_push && (CNT_W'(i) == r_count)) begin
                n_entries[i] = r_val;
            end else if (do_insert) begin
                if (CNT_W'(i) == pos_ext) begin
                    n_entries[i] = r_val;
                end else if (CNT_W'(i) > pos_ext) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_erase) begin
                if ((CNT_W'(i) >= pos_ext) && (i < DEPTH - 1)) begin
                    n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
        if (i_ctrl.exec) begin
            r_entries <= n_entries;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_count;

endmodule

// ===== hdl/indexed_list_engine_core.sv =====
// Channel   Handshake            Payload
// request   start, busy          i_mode, i_position, i_item_value
// result    o_valid (strobe)     o_status, o_entry_count
//
// A request is taken when start is high and busy is low. It executes in the
// next cycle, with busy high, and its result beat is strobed on o_valid in
// the cycle after that; a new request may start during the result beat.
// The whole entry row shifts in the execute cycle.
// Reset is synchronous and active low; it empties the list at once.
// The receiver cannot stall: each result is strobed for one cycle only.
module indexed_list_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ile_pkg::MODE_W-1:0]        i_mode,
    input  logic [ile_pkg::POS_W-1:0]         i_position,
    input  logic signed [ile_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_valid,
    output logic [ile_pkg::STAT_W-1:0]        o_status,
    output logic [ile_pkg::CNT_W-1:0]         o_entry_count
);
    import ile_pkg::*;

    t_ctrl ctrl;

    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_ctrl  (ctrl)
    );

    ile_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
